/* hw/rtl/activity_idle_detector_assert.svh */
// Assertion macros used by the idle detector core RTL
`ifndef ACTIVITY_IDLE_DETECTOR_ASSERT_SVH
`define ACTIVITY_IDLE_DETECTOR_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define AID_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication
`define AID_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define AID_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/aid_pkg.sv */
// Package: types, register indexes and constants of the idle detector
`default_nettype none

package aid_pkg;

	localparam int HISTORY_DEPTH_DEF = 9;
	localparam int COUNT_WIDTH_DEF   = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESCUE_INTERVAL = 2'd1;

	localparam logic [7:0]  IDLE_THRESHOLD_RST  = 8'd3;
	localparam logic [31:0] RESCUE_INTERVAL_RST = 32'd600;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_WAKE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] activity_total;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic        run_idle_work;
		logic [7:0]  idle_count;
		logic [29:0] reference_level;
		logic        window_full;
	} out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/activity_idle_detector.sv */
// Top level of the activity idle detector
//
//  channel   dir  handshake                  payload
//  tick      in   tick_valid / tick_stall    tick_data   (aid_pkg::in_item_t)
//  result    out  result_valid / result_stall result_data (aid_pkg::out_item_t)
//  cfg       in   cfg_we                     cfg_index, cfg_data
//
// One request per cycle while result_stall stays low; each request passes through the
// input register, delta stage, two reciprocal-multiply stages for the divide by the window
// depth and the result register. The window and quiet-count update is registered with the result.
// Reset clears all pipeline valids and detector state at once; no sweep follows.
// Each stage fills a bubble under a stalled result, so tick_stall rises only once
// all stages hold requests and result_stall is high.
`default_nettype none

module activity_idle_detector #(
	parameter int HISTORY_DEPTH = aid_pkg::HISTORY_DEPTH_DEF,
	parameter int COUNT_WIDTH   = aid_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           tick_valid,
	output logic                                tick_stall,
	input  wire aid_pkg::in_item_t              tick_data,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output aid_pkg::out_item_t                  result_data,
	input  wire logic                           cfg_we,
	input  wire logic [aid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import aid_pkg::*;

	localparam int L  = $clog2(HISTORY_DEPTH);
	localparam int RW = (L > 0) ? L : 1;

	logic                   f_valid, f_ready, f_kind;
	logic [31:0]            f_now;
	logic [COUNT_WIDTH-1:0] f_delta;
	logic                   d_valid, d_ready, d_kind;
	logic [31:0]            d_now;
	logic [COUNT_WIDTH-1:0] d_delta, d_quot;
	logic [RW-1:0]          d_rem;

	aid_front #(
		.CW(COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick_data (tick_data),
		.valid     (f_valid),
		.kind      (f_kind),
		.now       (f_now),
		.delta     (f_delta),
		.ready     (f_ready)
	);

	aid_recip #(
		.D (HISTORY_DEPTH),
		.CW(COUNT_WIDTH)
	) u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(f_valid),
		.up_ready(f_ready),
		.up_kind (f_kind),
		.up_now  (f_now),
		.up_delta(f_delta),
		.valid   (d_valid),
		.kind    (d_kind),
		.now     (d_now),
		.delta   (d_delta),
		.quot    (d_quot),
		.rem     (d_rem),
		.ready   (d_ready)
	);

	aid_core #(
		.D (HISTORY_DEPTH),
		.CW(COUNT_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (d_valid),
		.up_ready    (d_ready),
		.up_kind     (d_kind),
		.up_now      (d_now),
		.up_delta    (d_delta),
		.up_quot     (d_quot),
		.up_rem      (d_rem),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

endmodule

`default_nettype wire

/* hw/rtl/aid_front.sv */
// Input register and activity delta stage
`default_nettype none

module aid_front #(
	parameter int CW = aid_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tick_valid,
	output logic                  tick_stall,
	input  wire aid_pkg::in_item_t tick_data,
	output logic                  valid,
	output logic                  kind,
	output logic [31:0]           now,
	output logic [CW-1:0]         delta,
	input  wire logic             ready
);
	import aid_pkg::*;

	logic          valid_s1, kind_s1;
	logic [CW-1:0] total_s1;
	logic [31:0]   now_s1;
	logic          valid_s2, kind_s2;
	logic [31:0]   now_s2;
	logic [CW-1:0] delta_s2;
	logic [CW-1:0] prev_total_q;
	logic          ready_s1, ready_s2;

	assign ready_s2   = !valid_s2 || ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign tick_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			prev_total_q <= '0;
		end else begin
			if (ready_s1)
				valid_s1 <= tick_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			// track the count of the last tick as it leaves the input register
			if (valid_s1 && ready_s2 && kind_s1 == KIND_TICK)
				prev_total_q <= total_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && tick_valid) begin
			kind_s1  <= tick_data.kind;
			total_s1 <= tick_data.activity_total[CW-1:0];
			now_s1   <= tick_data.now_seconds;
		end
		if (ready_s2 && valid_s1) begin
			kind_s2  <= kind_s1;
			now_s2   <= now_s1;
			delta_s2 <= total_s1 - prev_total_q;
		end
	end

	assign valid = valid_s2;
	assign kind  = kind_s2;
	assign now   = now_s2;
	assign delta = delta_s2;

endmodule

`default_nettype wire

/* hw/rtl/aid_recip.sv */
// Divide of the delta by the window depth through a reciprocal multiply
`default_nettype none

module aid_recip #(
	parameter int D  = aid_pkg::HISTORY_DEPTH_DEF,
	parameter int CW = aid_pkg::COUNT_WIDTH_DEF,
	localparam int L  = $clog2(D),
	localparam int RW = (L > 0) ? L : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire logic          up_kind,
	input  wire logic [31:0]   up_now,
	input  wire logic [CW-1:0] up_delta,
	output logic               valid,
	output logic               kind,
	output logic [31:0]        now,
	output logic [CW-1:0]      delta,
	output logic [CW-1:0]      quot,
	output logic [RW-1:0]      rem,
	input  wire logic          ready
);
	import aid_pkg::*;

	// m = ceil(2^(CW+L) / D) gives an exact quotient for every CW-bit value
	localparam int K  = CW + L;
	localparam int MW = CW + 1;
	localparam int PW = CW + MW;
	localparam logic [63:0] M_FULL = ((64'd1 << K) + 64'(D) - 64'd1) / 64'(D);
	localparam logic [MW-1:0] MULT = M_FULL[MW-1:0];

	logic          valid_s3, kind_s3;
	logic [31:0]   now_s3;
	logic [CW-1:0] delta_s3;
	logic [PW-1:0] prod_s3;
	logic          valid_s4, kind_s4;
	logic [31:0]   now_s4;
	logic [CW-1:0] delta_s4, quot_s4;
	logic [RW-1:0] rem_s4;
	logic          ready_s3, ready_s4;
	logic [PW-1:0] prod_d, qfull;
	logic [CW-1:0] quot_d, rfull, dvsr;

	assign ready_s4 = !valid_s4 || ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign up_ready = ready_s3;

	assign prod_d = PW'(up_delta) * PW'(MULT);
	assign qfull  = prod_s3 >> K;
	assign quot_d = qfull[CW-1:0];
	assign dvsr   = CW'(D);
	assign rfull  = delta_s3 - quot_d * dvsr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3)
				valid_s3 <= up_valid;
			if (ready_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && up_valid) begin
			kind_s3  <= up_kind;
			now_s3   <= up_now;
			delta_s3 <= up_delta;
			prod_s3  <= prod_d;
		end
		if (ready_s4 && valid_s3) begin
			kind_s4  <= kind_s3;
			now_s4   <= now_s3;
			delta_s4 <= delta_s3;
			quot_s4  <= quot_d;
			rem_s4   <= rfull[RW-1:0];
		end
	end

	assign valid = valid_s4;
	assign kind  = kind_s4;
	assign now   = now_s4;
	assign delta = delta_s4;
	assign quot  = quot_s4;
	assign rem   = rem_s4;

endmodule

`default_nettype wire

/* hw/rtl/aid_core.sv */
// Window state, quiet counting, run decision, config registers and result register
`default_nettype none

`include "activity_idle_detector_assert.svh"

module aid_core #(
	parameter int D  = aid_pkg::HISTORY_DEPTH_DEF,
	parameter int CW = aid_pkg::COUNT_WIDTH_DEF,
	localparam int L  = $clog2(D),
	localparam int RW = (L > 0) ? L : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          up_valid,
	output logic                               up_ready,
	input  wire logic                          up_kind,
	input  wire logic [31:0]                   up_now,
	input  wire logic [CW-1:0]                 up_delta,
	input  wire logic [CW-1:0]                 up_quot,
	input  wire logic [RW-1:0]                 up_rem,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output aid_pkg::out_item_t                 result_data,
	input  wire logic                          cfg_we,
	input  wire logic [aid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [aid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import aid_pkg::*;

	localparam int FW = $clog2(D + 1);
	localparam logic signed [RW+1:0] DS = (RW+2)'(D);

	logic [CW-1:0] winq_q [D];
	logic [RW-1:0] winr_q [D];
	logic [FW-1:0] fill_q;
	logic [CW-1:0] qsum_q;
	logic [RW-1:0] rsum_q;
	logic [7:0]    quiet_q;
	logic [31:0]   last_run_q;
	logic [7:0]    thr_q;
	logic [31:0]   rescue_q;
	logic          result_valid_q;
	out_item_t     res_data_q;

	logic                 res_ready, core_load, is_tick, full, quiet_hit, rescue, run;
	logic [CW-3:0]        ref_lvl;
	logic [CW-1:0]        sub_q, qs, qn;
	logic [RW-1:0]        sub_r, rn;
	logic signed [RW+1:0] rs, rs_lo, rs_hi;
	logic [7:0]           quiet_t;
	logic [31:0]          since_run;
	out_item_t            res_d;

	assign res_ready = !result_valid_q || !result_stall;
	assign up_ready  = res_ready;
	assign core_load = up_valid && res_ready;

	assign is_tick   = (up_kind == KIND_TICK);
	assign full      = (fill_q == FW'(D));
	assign ref_lvl   = qsum_q[CW-1:2];
	assign quiet_hit = (up_delta <= CW'(ref_lvl));

	// running quotient and remainder of the window sum; quotient is the average
	assign sub_q = full ? winq_q[D-1] : '0;
	assign sub_r = full ? winr_q[D-1] : '0;
	assign qs    = qsum_q + up_quot - sub_q;
	assign rs    = $signed({2'b00, rsum_q}) + $signed({2'b00, up_rem}) - $signed({2'b00, sub_r});
	assign rs_lo = rs + DS;
	assign rs_hi = rs - DS;

	always_comb begin
		if (rs < 0) begin
			qn = qs - CW'(1);
			rn = rs_lo[RW-1:0];
		end else if (rs >= DS) begin
			qn = qs + CW'(1);
			rn = rs_hi[RW-1:0];
		end else begin
			qn = qs;
			rn = rs[RW-1:0];
		end
	end

	always_comb begin
		quiet_t = quiet_q;
		if (is_tick) begin
			if (!full)
				quiet_t = 8'd0;
			else if (!quiet_hit)
				quiet_t = 8'd0;
			else if (quiet_q != 8'hFF)
				quiet_t = quiet_q + 8'd1;
		end
	end

	assign since_run = up_now - last_run_q;
	assign rescue    = (since_run > rescue_q);
	assign run       = !is_tick || rescue || (quiet_t >= thr_q);

	always_comb begin
		res_d.run_idle_work   = run;
		res_d.idle_count      = run ? 8'd0 : quiet_t;
		res_d.reference_level = (is_tick && full) ? 30'(ref_lvl) : 30'd0;
		res_d.window_full     = is_tick && full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			qsum_q         <= '0;
			rsum_q         <= '0;
			quiet_q        <= 8'd0;
			last_run_q     <= 32'd0;
			thr_q          <= IDLE_THRESHOLD_RST;
			rescue_q       <= RESCUE_INTERVAL_RST;
			result_valid_q <= 1'b0;
		end else begin
			if (res_ready)
				result_valid_q <= up_valid;
			if (core_load) begin
				if (is_tick) begin
					if (!full)
						fill_q <= fill_q + FW'(1);
					qsum_q  <= qn;
					rsum_q  <= rn;
					quiet_q <= quiet_t;
				end
				if (run) begin
					fill_q     <= '0;
					qsum_q     <= '0;
					rsum_q     <= '0;
					quiet_q    <= 8'd0;
					last_run_q <= up_now;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IDLE_THRESHOLD:  thr_q    <= cfg_data[7:0];
					CFG_RESCUE_INTERVAL: rescue_q <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

	// window taps: newest enters at the head, oldest sits at the last tap once full
	always_ff @(posedge clk) begin
		if (core_load && is_tick) begin
			winq_q[0] <= up_quot;
			winr_q[0] <= up_rem;
			for (int i = 1; i < D; i++) begin
				winq_q[i] <= winq_q[i-1];
				winr_q[i] <= winr_q[i-1];
			end
		end
		if (core_load)
			res_data_q <= res_d;
	end

	assign result_valid = result_valid_q;
	assign result_data  = res_data_q;

	`AID_ASSERT(a_fill_bound, fill_q <= FW'(D), "window fill beyond depth")
	`AID_ASSERT(a_rem_bound, {1'b0, rsum_q} < (RW+1)'(D), "window remainder not normalized")
	`AID_NEXT(a_run_clears, core_load && run, fill_q == '0 && quiet_q == 8'd0 && qsum_q == '0, "run left window or quiet count set")
	`AID_IMPLY(a_quiet_full, result_valid_q && res_data_q.idle_count != 8'd0, res_data_q.window_full && !res_data_q.run_idle_work, "quiet count without full window compare")

endmodule

`default_nettype wire

/* tb/activity_idle_detector_chk.sv */
// Checker for the idle detector: mirrors its registers, predicts every verdict, compares results
`timescale 1ns / 100ps

module activity_idle_detector_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	input  logic                           tick_stall,
	input  aid_pkg::in_item_t              tick_data,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  aid_pkg::out_item_t             result_data,
	input  logic                           cfg_we,
	input  logic [aid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aid_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             verdicts_waiting,
	output int                             verdicts_checked,
	output int                             runs_predicted,
	output int                             compares_predicted
);

	localparam int HIST_DEPTH = aid_pkg::HISTORY_DEPTH_DEF;

	// mirrored registers
	logic [7:0]  quiet_needed;
	logic [31:0] rescue_secs;

	// detector state
	logic [31:0] delta_hist [HIST_DEPTH];
	int unsigned hist_head;
	int unsigned hist_fill;
	logic [35:0] hist_sum;
	logic [31:0] last_total;
	logic [31:0] last_run_at;
	logic [7:0]  quiet_run;

	aid_pkg::out_item_t idle_verdicts_due [$];
	int bad_count;
	int checked_count;
	int run_count;
	int compare_count;

	function automatic void flush_history();
		for (int k = 0; k < HIST_DEPTH; k++)
			delta_hist[k] = '0;
		hist_head = 0;
		hist_fill = 0;
		hist_sum  = '0;
	endfunction

	function automatic aid_pkg::out_item_t compute_idle_verdict(aid_pkg::in_item_t req);
		aid_pkg::out_item_t v;
		logic [31:0] delta;
		logic [35:0] mean;
		logic run;
		v   = '0;
		run = 1'b0;
		if (req.kind == aid_pkg::KIND_TICK) begin
			delta      = req.activity_total - last_total;
			last_total = req.activity_total;
			if (hist_fill < HIST_DEPTH) begin
				quiet_run = '0;
				delta_hist[(hist_head + hist_fill) % HIST_DEPTH] = delta;
				hist_sum  = hist_sum + 36'(delta);
				hist_fill = hist_fill + 1;
			end else begin
				mean = hist_sum / 36'(HIST_DEPTH);
				v.reference_level = mean[31:2];
				v.window_full     = 1'b1;
				if (delta <= 32'(v.reference_level)) begin
					if (quiet_run != 8'hFF)
						quiet_run = quiet_run + 8'd1;
				end else begin
					quiet_run = '0;
				end
				// drop the oldest delta, append the new one
				hist_sum = hist_sum - 36'(delta_hist[hist_head]) + 36'(delta);
				delta_hist[hist_head] = delta;
				hist_head = (hist_head + 1) % HIST_DEPTH;
			end
		end else begin
			run = 1'b1;
		end
		if (32'(req.now_seconds - last_run_at) > rescue_secs)
			run = 1'b1;
		if (quiet_run >= quiet_needed)
			run = 1'b1;
		if (run) begin
			quiet_run   = '0;
			last_run_at = req.now_seconds;
			flush_history();
		end
		v.run_idle_work = run;
		v.idle_count    = quiet_run;
		return v;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			bad_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		aid_pkg::out_item_t want;
		if (!arst_n) begin
			quiet_needed = aid_pkg::IDLE_THRESHOLD_RST;
			rescue_secs  = aid_pkg::RESCUE_INTERVAL_RST;
			flush_history();
			last_total    = '0;
			last_run_at   = '0;
			quiet_run     = '0;
			idle_verdicts_due.delete();
			bad_count     = 0;
			checked_count = 0;
			run_count     = 0;
			compare_count = 0;
		end else begin
			// check results before taking this edge's request
			if (result_valid && !result_stall) begin
				if (idle_verdicts_due.size() == 0) begin
					$error("result with no request outstanding: %p", result_data);
					bad_count++;
				end else begin
					want = idle_verdicts_due[0];
					idle_verdicts_due.delete(0);
					check_field("run_idle_work", want.run_idle_work, result_data.run_idle_work);
					check_field("idle_count", want.idle_count, result_data.idle_count);
					check_field("reference_level", want.reference_level,
						result_data.reference_level);
					check_field("window_full", want.window_full, result_data.window_full);
					checked_count++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == aid_pkg::CFG_IDLE_THRESHOLD)
					quiet_needed = cfg_data[7:0];
				else if (cfg_index == aid_pkg::CFG_RESCUE_INTERVAL)
					rescue_secs = cfg_data;
			end
			if (tick_valid && !tick_stall) begin
				want = compute_idle_verdict(tick_data);
				idle_verdicts_due = {idle_verdicts_due, want};
				if (want.run_idle_work)
					run_count++;
				if (want.window_full)
					compare_count++;
			end
		end
		mismatches         <= bad_count;
		verdicts_waiting   <= idle_verdicts_due.size();
		verdicts_checked   <= checked_count;
		runs_predicted     <= run_count;
		compares_predicted <= compare_count;
	end

endmodule

/* tb/activity_idle_detector_tb.sv */
// Testbench top: drives ticks, wakes and register writes into the idle detector, gives the verdict
`timescale 1ns / 100ps

module activity_idle_detector_tb;

	localparam int CYCLE_LIMIT = 250000;
	localparam int ITEM_TARGET = 1100;
	localparam int HOLD_CYCLES = 80;

	// indexes outside the register map, written to check they are ignored
	localparam logic [aid_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
	localparam logic [aid_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           tick_valid   = 1'b0;
	logic                           tick_stall;
	aid_pkg::in_item_t              tick_data    = '0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	aid_pkg::out_item_t             result_data;
	logic                           cfg_we       = 1'b0;
	logic [aid_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [aid_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	int mismatches;
	int verdicts_waiting;
	int verdicts_checked;
	int runs_predicted;
	int compares_predicted;

	logic        no_idle   = 1'b0;
	int          hold_ask  = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          sent      = 0;
	int          cycle_count = 0;
	logic [31:0] act_total  = '0;
	logic [31:0] clock_secs = '0;
	logic [7:0]  cur_threshold = aid_pkg::IDLE_THRESHOLD_RST;
	logic [31:0] cur_rescue    = aid_pkg::RESCUE_INTERVAL_RST;

	activity_idle_detector u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick_data    (tick_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	activity_idle_detector_chk u_chk (
		.clk                (clk),
		.arst_n             (arst_n),
		.tick_valid         (tick_valid),
		.tick_stall         (tick_stall),
		.tick_data          (tick_data),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.result_data        (result_data),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mismatches         (mismatches),
		.verdicts_waiting   (verdicts_waiting),
		.verdicts_checked   (verdicts_checked),
		.runs_predicted     (runs_predicted),
		.compares_predicted (compares_predicted)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("activity_idle_detector_tb NOT OK");
		$finish;
	end

	// result side: random stalls, plus a long hold-off whenever one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (hold_ask != hold_seen) begin
			hold_seen    <= hold_ask;
			hold_left    <= HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !no_idle && ($urandom_range(99) < 32);
		end
	end

	function automatic aid_pkg::in_item_t make_req(logic kind, logic [31:0] total,
		logic [31:0] secs);
		aid_pkg::in_item_t r;
		r.kind           = kind;
		r.activity_total = total;
		r.now_seconds    = secs;
		return r;
	endfunction

	// offer one request and hold it until taken; valid stays high into the next call
	task automatic send_req(input aid_pkg::in_item_t r);
		while (!no_idle && $urandom_range(99) < 32) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_data  <= r;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_tick(input logic [31:0] delta, input logic [31:0] step);
		act_total  = act_total + delta;
		clock_secs = clock_secs + step;
		send_req(make_req(aid_pkg::KIND_TICK, act_total, clock_secs));
	endtask

	task automatic send_wake(input logic [31:0] step);
		clock_secs = clock_secs + step;
		send_req(make_req(aid_pkg::KIND_WAKE, $urandom, clock_secs));
	endtask

	// mostly ticks, with the odd wake, a rescue-sized time jump, or a fully random request
	task automatic offer_tick(input logic [31:0] delta);
		int unsigned pick;
		logic [31:0] step;
		pick = $urandom_range(99);
		step = ($urandom_range(24) == 0) ? cur_rescue + $urandom_range(2) : $urandom_range(3);
		if (pick < 3)
			send_wake(step);
		else if (pick < 8)
			send_req(make_req(1'($urandom_range(1)), $urandom, $urandom));
		else
			send_tick(delta, step);
	endtask

	// busy ticks, often enough to fill the window, then a quiet streak with the odd busy tick
	task automatic run_episode();
		logic [31:0] base;
		int unsigned fill_n;
		int unsigned quiet_n;
		base = ($urandom_range(3) == 0) ? $urandom_range(32'h0FFF_FFFF, 32'h1000)
			: $urandom_range(2000, 20);
		fill_n  = $urandom_range(11, 6);
		quiet_n = $urandom_range((cur_threshold > 12) ? 14 : cur_threshold + 2, 0);
		for (int i = 0; i < fill_n; i++)
			offer_tick($urandom_range(2 * base, base / 2));
		for (int i = 0; i < quiet_n; i++) begin
			if ($urandom_range(9) == 0)
				offer_tick($urandom_range(2 * base, base / 2));
			else if ($urandom_range(1) == 0)
				offer_tick('0);
			else
				offer_tick($urandom_range(base / 16, 0));
		end
	endtask

	// drop valid and wait until every request has its result, then let the pipe settle
	task automatic drain_results();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_waiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [aid_pkg::CFG_IDX_W-1:0] idx,
		input logic [aid_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == aid_pkg::CFG_IDLE_THRESHOLD)
			cur_threshold = data[7:0];
		else if (idx == aid_pkg::CFG_RESCUE_INTERVAL)
			cur_rescue = data;
	endtask

	initial begin : stimulus
		int phase_end;
		int phase_no;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: threshold 3, rescue 600
		send_wake(0);
		// all-ones deltas fill the window and drive the reference level to its top
		for (int i = 0; i < 9; i++)
			send_tick(32'hFFFF_FFFF, 1);
		send_tick(32'h3FFF_FFFF, 1);   // equal to the reference level: quiet
		send_tick(0, 1);
		send_tick(5, 1);               // third quiet tick: run
		send_tick(32'hFFFF_FFFF - act_total, 1);
		send_tick(5, 1);               // count wraps through zero
		send_tick(0, 612 - clock_secs); // exactly the rescue interval since the run
		send_tick(0, 1);               // one second past it: forced run
		send_tick(1, 32'hFFFF_FFFF - clock_secs);
		send_tick(1, 6);               // time wraps
		send_wake(32'h8000_0000);
		drain_results();

		write_reg(CFG_UNMAPPED_A, $urandom);
		write_reg(CFG_UNMAPPED_B, $urandom);
		write_reg(aid_pkg::CFG_IDLE_THRESHOLD, 32'hFFFF_FF01);
		write_reg(aid_pkg::CFG_RESCUE_INTERVAL, 32'hFFFF_FFFF);
		while (sent < 200)
			run_episode();
		drain_results();

		// threshold zero: every request runs
		write_reg(aid_pkg::CFG_IDLE_THRESHOLD, 32'h1234_5600);
		write_reg(aid_pkg::CFG_RESCUE_INTERVAL, aid_pkg::RESCUE_INTERVAL_RST);
		for (int i = 0; i < 15; i++)
			offer_tick($urandom_range(500));
		drain_results();

		// rescue interval zero: any time change forces a run
		write_reg(aid_pkg::CFG_IDLE_THRESHOLD, 32'd4);
		write_reg(aid_pkg::CFG_RESCUE_INTERVAL, 32'd0);
		for (int i = 0; i < 30; i++) begin
			if ($urandom_range(1) == 0)
				send_tick($urandom_range(50), 0);
			else
				offer_tick($urandom_range(50));
		end
		drain_results();

		// top threshold: the quiet count climbs all the way to 255
		write_reg(aid_pkg::CFG_IDLE_THRESHOLD, 32'd255);
		write_reg(aid_pkg::CFG_RESCUE_INTERVAL, 32'hFFFF_FFFF);
		for (int i = 0; i < 9; i++)
			send_tick(1000, 1);
		for (int i = 0; i < 257; i++)
			send_tick(0, 0);
		drain_results();

		phase_no = 0;
		no_idle <= 1'b1;
		while (sent < ITEM_TARGET) begin
			drain_results();
			write_reg(aid_pkg::CFG_IDLE_THRESHOLD,
				($urandom & 32'hFFFF_FF00) | $urandom_range(12, 1));
			case ($urandom_range(3))
				0: write_reg(aid_pkg::CFG_RESCUE_INTERVAL, $urandom_range(300, 5));
				1: write_reg(aid_pkg::CFG_RESCUE_INTERVAL, aid_pkg::RESCUE_INTERVAL_RST);
				2: write_reg(aid_pkg::CFG_RESCUE_INTERVAL, 32'hFFFF_FFFF);
				default: write_reg(aid_pkg::CFG_RESCUE_INTERVAL, $urandom);
			endcase
			// hold off the result side while requests keep coming, so the pipe backs up
			if (phase_no == 0)
				hold_ask <= hold_ask + 1;
			phase_end = sent + 120;
			while (sent < phase_end)
				run_episode();
			if (phase_no == 0)
				no_idle <= 1'b0;
			phase_no++;
		end
		drain_results();
		repeat (10) @(posedge clk);

		$display("Ran %0d requests; %0d results checked, %0d idle-work runs, %0d full-window compares",
			sent, verdicts_checked, runs_predicted, compares_predicted);
		$display("Thresholds 0..255, rescue intervals 0..max, unmapped writes, long result hold-off");
		if (mismatches == 0)
			$display("activity_idle_detector_tb OK");
		else
			$display("activity_idle_detector_tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/aid_pkg.sv
hw/rtl/aid_front.sv
hw/rtl/aid_recip.sv
hw/rtl/aid_core.sv
hw/rtl/activity_idle_detector.sv
tb/activity_idle_detector_chk.sv
tb/activity_idle_detector_tb.sv
